// File: rtl/core/crpf_pkg.sv
// ----------------------------------------------------------------------------
// crpf_pkg: shared types and constants of the Catmull-Rom path follower
// Table size, time format, operation codes, register indexes and the command
// and status words between controller and datapath.
// ----------------------------------------------------------------------------
package crpf_pkg;

   localparam int MAX_POINTS = 64;
   localparam int FRAC_BITS  = 16;

   localparam int ADDR_W   = $clog2(MAX_POINTS);
   localparam int N_W      = $clog2(MAX_POINTS + 1);
   localparam int PT_W     = FRAC_BITS + 2;
   localparam int T_W      = FRAC_BITS + 1;
   localparam int SCL_W    = PT_W + N_W;
   localparam int SEGF_W   = SCL_W - FRAC_BITS;
   localparam int ACC_W    = 40;
   localparam int PROD_W   = ACC_W + FRAC_BITS + 2;
   localparam int POINT_W  = 96;
   localparam int COORD_W  = 32;

   localparam int MIN_POINTS = 4;
   localparam int TAIL_POINTS = 3;

   localparam logic [T_W-1:0]  ONE_T    = T_W'(1) << FRAC_BITS;
   localparam logic [PT_W-1:0] PT_ONE   = PT_W'(1) << FRAC_BITS;
   localparam logic [PT_W-1:0] TIME_MAX = {PT_W{1'b1}};
   localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_BITS - 1);
   localparam logic signed [ACC_W-1:0]  SAT_HI = ACC_W'(64'sd2147483647);
   localparam logic signed [ACC_W-1:0]  SAT_LO = -SAT_HI - ACC_W'(1);

   // field widths fixed by the interface
   localparam int OP_W     = 2;
   localparam int INDEX_W  = 6;
   localparam int SEG_OUT_W = 6;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;
   localparam int COUNT_W  = 7;
   localparam int SPEED_W  = 16;

   localparam logic [OP_W-1:0] OP_WRITE   = 2'd0;
   localparam logic [OP_W-1:0] OP_TICK    = 2'd1;
   localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_POINT_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_SPEED  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOOP_ENABLE = 2'd2;

   localparam logic [1:0] RD_LAST   = 2'd3;
   localparam logic [1:0] AXIS_LAST = 2'd2;

   typedef enum logic [1:0] {
      ADD_B,
      ADD_C,
      ADD_P1
   } add_sel_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_RDWAIT,
      S_COEF,
      S_MUL,
      S_ADD,
      S_FIN,
      S_DONE
   } state_type;

   typedef struct packed {
      logic        wr;
      logic        restart;
      logic        scale;
      logic        rd_en;
      logic [1:0]  rd_k;
      logic        coef;
      logic        mul;
      logic        add;
      add_sel_type add_sel;
      logic        fin;
      logic [1:0]  axis;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic few_points;
      logic out_free;
   } stat_type;

endpackage

// File: rtl/core/crpf_req_if.sv
// ----------------------------------------------------------------------------
// crpf_req_if: request channel
// Valid/ready channel carrying one operation word with its point payload.
// ----------------------------------------------------------------------------
interface crpf_req_if
   import crpf_pkg::*;
();
   logic                       valid;
   logic                       ready;
   logic [OP_W-1:0]            operation;
   logic [INDEX_W-1:0]         point_index;
   logic signed [COORD_W-1:0]  point_x;
   logic signed [COORD_W-1:0]  point_y;
   logic signed [COORD_W-1:0]  point_z;

   modport source (output valid, operation, point_index, point_x, point_y, point_z,
                   input ready);
   modport sink   (input valid, operation, point_index, point_x, point_y, point_z,
                   output ready);
endinterface

// File: rtl/core/crpf_rsp_if.sv
// ----------------------------------------------------------------------------
// crpf_rsp_if: response channel
// Valid/ready channel carrying one interpolated position word.
// ----------------------------------------------------------------------------
interface crpf_rsp_if
   import crpf_pkg::*;
();
   logic                       valid;
   logic                       ready;
   logic signed [COORD_W-1:0]  pos_x;
   logic signed [COORD_W-1:0]  pos_y;
   logic signed [COORD_W-1:0]  pos_z;
   logic [SEG_OUT_W-1:0]       segment_index;
   logic [T_W-1:0]             fraction;
   logic                       reached_end;

   modport source (output valid, pos_x, pos_y, pos_z, segment_index, fraction,
                   reached_end, input ready);
   modport sink   (input valid, pos_x, pos_y, pos_z, segment_index, fraction,
                   reached_end, output ready);
endinterface

// File: rtl/core/catmull_rom_path_follower.sv
// ----------------------------------------------------------------------------
// catmull_rom_path_follower: uniform Catmull-Rom path follower
// Write words store Q16.16 control points in a 64-entry table; a tick word
// picks the segment from the path time, evaluates the curve on four points
// and advances the time; a restart word rewinds. Writes, restarts and ticks
// with fewer than four points are done in the idle state. A tick that
// yields a position goes through segment selection, the four reads through
// the single table read port, the three Horner steps per axis on the one
// shared multiplier, and the load of the output register once it is free.
// A new word is taken while a result waits to be taken.
// ----------------------------------------------------------------------------
module catmull_rom_path_follower
   import crpf_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   crpf_req_if.sink             req_chan,
   crpf_rsp_if.source           rsp_chan,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_data
);
   cmd_type  cmd;
   stat_type stat;
   logic     ready;

   crpf_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_chan.valid),
      .req_operation (req_chan.operation),
      .req_ready     (ready),
      .stat          (stat),
      .cmd           (cmd)
   );

   assign req_chan.ready = ready;

   crpf_datapath u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .point_index   (req_chan.point_index),
      .point_x       (req_chan.point_x),
      .point_y       (req_chan.point_y),
      .point_z       (req_chan.point_z),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .pos_x         (rsp_chan.pos_x),
      .pos_y         (rsp_chan.pos_y),
      .pos_z         (rsp_chan.pos_z),
      .segment_index (rsp_chan.segment_index),
      .fraction      (rsp_chan.fraction),
      .reached_end   (rsp_chan.reached_end)
   );
endmodule

// File: rtl/core/crpf_ram.sv
// ----------------------------------------------------------------------------
// crpf_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module crpf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// File: rtl/core/crpf_ctrl.sv
// ----------------------------------------------------------------------------
// crpf_ctrl: path follower controller
// Sequences the table reads and the per-axis Horner steps on the shared
// multiplier, and hands the finished word to the output register.
// ----------------------------------------------------------------------------
module crpf_ctrl
   import crpf_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic [OP_W-1:0] req_operation,
   output logic            req_ready,
   input  stat_type        stat,
   output cmd_type         cmd
);
   state_type   state_ff, state_in;
   logic [1:0]  k_ff, k_in;
   logic [1:0]  axis_ff, axis_in;
   add_sel_type step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         k_ff     <= '0;
         axis_ff  <= '0;
         step_ff  <= ADD_B;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         axis_ff  <= axis_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      k_in        = k_ff;
      axis_in     = axis_ff;
      step_in     = step_ff;
      req_ready   = 1'b0;
      cmd         = '0;
      cmd.rd_k    = k_ff;
      cmd.axis    = axis_ff;
      cmd.add_sel = step_ff;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_operation == OP_WRITE) begin
                  cmd.wr = 1'b1;
               end else if (req_operation == OP_RESTART) begin
                  cmd.restart = 1'b1;
               end else if (req_operation == OP_TICK && !stat.few_points) begin
                  cmd.scale = 1'b1;
                  k_in      = '0;
                  state_in  = S_READ;
               end
            end
         end
         S_READ: begin
            cmd.rd_en = 1'b1;
            k_in      = k_ff + 2'd1;
            if (k_ff == RD_LAST) begin
               state_in = S_RDWAIT;
            end
         end
         S_RDWAIT: begin
            axis_in  = '0;
            state_in = S_COEF;
         end
         S_COEF: begin
            cmd.coef = 1'b1;
            step_in  = ADD_B;
            state_in = S_MUL;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_ADD;
         end
         S_ADD: begin
            cmd.add = 1'b1;
            case (step_ff)
               ADD_B: begin
                  step_in  = ADD_C;
                  state_in = S_MUL;
               end
               ADD_C: begin
                  step_in  = ADD_P1;
                  state_in = S_MUL;
               end
               default: begin
                  state_in = S_FIN;
               end
            endcase
         end
         S_FIN: begin
            cmd.fin = 1'b1;
            axis_in = axis_ff + 2'd1;
            state_in = (axis_ff == AXIS_LAST) ? S_DONE : S_COEF;
         end
         S_DONE: begin
            // hold until the output register is free
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end
endmodule

// File: rtl/core/crpf_datapath.sv
// ----------------------------------------------------------------------------
// crpf_datapath: path follower datapath
// Control point table, path time, segment selection, shared Horner multiplier
// and the output register.
// ----------------------------------------------------------------------------
module crpf_datapath
   import crpf_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  cmd_type                    cmd,
   output stat_type                   stat,
   input  logic                       csr_we,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DAT_W-1:0]       csr_data,
   input  logic [INDEX_W-1:0]         point_index,
   input  logic signed [COORD_W-1:0]  point_x,
   input  logic signed [COORD_W-1:0]  point_y,
   input  logic signed [COORD_W-1:0]  point_z,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [COORD_W-1:0]  pos_x,
   output logic signed [COORD_W-1:0]  pos_y,
   output logic signed [COORD_W-1:0]  pos_z,
   output logic [SEG_OUT_W-1:0]       segment_index,
   output logic [T_W-1:0]             fraction,
   output logic                       reached_end
);
   // configuration
   logic [COUNT_W-1:0] count_ff;
   logic [SPEED_W-1:0] speed_ff;
   logic               loop_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         speed_ff <= '0;
         loop_ff  <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_POINT_COUNT: count_ff <= csr_data[COUNT_W-1:0];
            CSR_STEP_SPEED:  speed_ff <= csr_data[SPEED_W-1:0];
            CSR_LOOP_ENABLE: loop_ff  <= csr_data[0];
            default: ;
         endcase
      end
   end

   logic [N_W-1:0] n_eff;
   logic [N_W-1:0] nseg;
   assign n_eff = (int'(count_ff) > MAX_POINTS) ? N_W'(MAX_POINTS) : N_W'(count_ff);
   assign nseg  = n_eff - N_W'(TAIL_POINTS);

   // control point table, word layout {z, y, x}
   logic              ram_we;
   logic [ADDR_W-1:0] ram_raddr;
   logic [POINT_W-1:0] ram_rdata;
   logic [ADDR_W-1:0] seg_ff, seg_in;

   assign ram_we    = cmd.wr && (int'(point_index) < MAX_POINTS);
   assign ram_raddr = seg_ff + ADDR_W'(cmd.rd_k);

   crpf_ram #(
      .WIDTH (POINT_W),
      .DEPTH (MAX_POINTS)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ADDR_W'(point_index)),
      .wdata ({point_z, point_y, point_x}),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // path time and segment selection
   logic [PT_W-1:0]   time_ff, time_in;
   logic              end_ff, end_in;
   logic [T_W-1:0]    t_ff, t_in;
   logic [SCL_W-1:0]  scaled;
   logic [SEGF_W-1:0] seg_full;
   logic [PT_W-1:0]   time_base;
   logic [PT_W:0]     time_sum;

   always_comb begin
      scaled    = SCL_W'(time_ff) * SCL_W'(nseg);
      seg_full  = scaled[SCL_W-1:FRAC_BITS];
      seg_in    = seg_ff;
      t_in      = t_ff;
      end_in    = end_ff;
      time_in   = time_ff;
      time_base = time_ff;
      if (seg_full >= SEGF_W'(nseg)) begin
         if (loop_ff) begin
            seg_in    = '0;
            t_in      = '0;
            time_base = '0;
         end else begin
            seg_in    = ADDR_W'(nseg - N_W'(1));
            t_in      = ONE_T;
            time_base = PT_ONE;
            end_in    = 1'b1;
         end
      end else begin
         seg_in = seg_full[ADDR_W-1:0];
         t_in   = {1'b0, scaled[FRAC_BITS-1:0]};
      end
      time_sum = {1'b0, time_base} + (PT_W + 1)'(speed_ff);
      if (cmd.scale) begin
         time_in = time_sum[PT_W] ? TIME_MAX : time_sum[PT_W-1:0];
      end else if (cmd.restart) begin
         time_in = '0;
         end_in  = 1'b0;
      end else begin
         seg_in = seg_ff;
         t_in   = t_ff;
         end_in = end_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff <= '0;
         end_ff  <= 1'b0;
      end else begin
         time_ff <= time_in;
         end_ff  <= end_in;
      end
   end

   always_ff @(posedge clock) begin
      seg_ff <= seg_in;
      t_ff   <= t_in;
   end

   // capture read data in the cycle after each table read
   logic               rd_pend_ff;
   logic [1:0]         rd_idx_ff;
   logic [POINT_W-1:0] p_ff [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff <= 1'b0;
      end else begin
         rd_pend_ff <= cmd.rd_en;
      end
      rd_idx_ff <= cmd.rd_k;
      if (rd_pend_ff) begin
         p_ff[rd_idx_ff] <= ram_rdata;
      end
   end

   // Horner evaluation on one axis at a time
   logic signed [ACC_W-1:0]  e0, e1, e2, e3;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [ACC_W-1:0]  b_ff, c_ff, p1x2_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] rsum;
   logic signed [PROD_W-1:0] rshift;
   logic signed [ACC_W-1:0]  addend;
   logic signed [ACC_W-1:0]  half;
   logic signed [COORD_W-1:0] sat_val;
   logic signed [T_W:0]      t_signed;
   logic signed [COORD_W-1:0] res_ff [3];

   assign e0 = ACC_W'($signed(p_ff[0][cmd.axis*COORD_W +: COORD_W]));
   assign e1 = ACC_W'($signed(p_ff[1][cmd.axis*COORD_W +: COORD_W]));
   assign e2 = ACC_W'($signed(p_ff[2][cmd.axis*COORD_W +: COORD_W]));
   assign e3 = ACC_W'($signed(p_ff[3][cmd.axis*COORD_W +: COORD_W]));
   assign t_signed = $signed({1'b0, t_ff});

   always_comb begin
      case (cmd.add_sel)
         ADD_B:   addend = b_ff;
         ADD_C:   addend = c_ff;
         ADD_P1:  addend = p1x2_ff;
         default: addend = '0;
      endcase
      // round to nearest, ties up
      rsum   = prod_ff + ROUND_HALF;
      rshift = rsum >>> FRAC_BITS;
      acc_in = ACC_W'(rshift) + addend;
      half   = (acc_ff + ACC_W'(1)) >>> 1;
      if (half > SAT_HI) begin
         sat_val = SAT_HI[COORD_W-1:0];
      end else if (half < SAT_LO) begin
         sat_val = SAT_LO[COORD_W-1:0];
      end else begin
         sat_val = half[COORD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.coef) begin
         acc_ff  <= -e0 + 3 * e1 - 3 * e2 + e3;
         b_ff    <= 2 * e0 - 5 * e1 + 4 * e2 - e3;
         c_ff    <= e2 - e0;
         p1x2_ff <= 2 * e1;
      end else if (cmd.add) begin
         acc_ff <= acc_in;
      end
      if (cmd.mul) begin
         prod_ff <= PROD_W'(acc_ff) * PROD_W'(t_signed);
      end
      if (cmd.fin) begin
         res_ff[cmd.axis] <= sat_val;
      end
   end

   // output register
   logic                      valid_ff;
   logic signed [COORD_W-1:0] ox_ff, oy_ff, oz_ff;
   logic [SEG_OUT_W-1:0]      oseg_ff;
   logic [T_W-1:0]            ofrac_ff;
   logic                      oend_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         ox_ff    <= res_ff[0];
         oy_ff    <= res_ff[1];
         oz_ff    <= res_ff[2];
         oseg_ff  <= SEG_OUT_W'(seg_ff);
         ofrac_ff <= t_ff;
         oend_ff  <= end_ff;
      end
   end

   assign stat.few_points = (int'(n_eff) < MIN_POINTS);
   assign stat.out_free   = !valid_ff || rsp_ready;

   assign rsp_valid     = valid_ff;
   assign pos_x         = ox_ff;
   assign pos_y         = oy_ff;
   assign pos_z         = oz_ff;
   assign segment_index = oseg_ff;
   assign fraction      = ofrac_ff;
   assign reached_end   = oend_ff;
endmodule

// File: rtl/core/crpf_checker.sv
// ----------------------------------------------------------------------------
// crpf_checker: port-level checks of the path follower
// Watches the response channel for handshake and value consistency.
// ----------------------------------------------------------------------------
module crpf_checker
   import crpf_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [SEG_OUT_W-1:0] segment_index,
   input logic [T_W-1:0]       fraction,
   input logic                 reached_end
);
   // a pending word stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before acceptance");

   a_frac_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> fraction <= ONE_T)
      else $error("fraction above one");

   // full fraction only comes from holding at the end
   a_end_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && fraction == ONE_T |-> reached_end)
      else $error("fraction one without end flag");

   a_seg_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> int'(segment_index) <= MAX_POINTS - MIN_POINTS)
      else $error("segment beyond table");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");
endmodule

bind catmull_rom_path_follower crpf_checker u_crpf_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .segment_index (rsp_chan.segment_index),
   .fraction      (rsp_chan.fraction),
   .reached_end   (rsp_chan.reached_end)
);
